### sv/rlpa_pkg.sv
// rlpa_pkg: shared constants, register codes and control structs for the
// range line parser/averager. Depends on nothing; every rlpa module imports it.
package rlpa_pkg;

  // default geometry
  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int LINE_CAPACITY_DEF = 16;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 14;
  localparam int SKIP_W     = 8;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 1;

  // line format
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LEAD = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
  localparam int LINE_LEN = 5;

  // register reset values
  localparam logic [SKIP_W-1:0]   SKIP_COUNT_RESET  = 8'd5;
  localparam logic [SAMPLE_W-1:0] UPPER_LIMIT_RESET = 14'd5000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP_COUNT  = 1'b0,
    CFG_UPPER_LIMIT = 1'b1
  } cfg_index_t;

  // parser to history: line end and its verdict
  typedef struct packed {
    logic                eol;
    logic                ok;
    logic [SAMPLE_W-1:0] value;
  } line_status_t;

  // history to output pipeline
  typedef struct packed {
    logic stored;
    logic full;
  } hist_flags_t;

endpackage

### sv/rlpa_line_parser.sv
// rlpa_line_parser: collects received bytes into a line and judges it at
// carriage return. Depends on rlpa_pkg.
module rlpa_line_parser
  import rlpa_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic [SAMPLE_W-1:0] upper_limit,
  output line_status_t        status
);

  localparam int LEN_W = $clog2(LINE_CAPACITY + 2);

  logic [LEN_W-1:0]    line_length_r, line_length_nxt;
  logic                first_is_r_r, first_is_r_nxt;
  logic                digits_ok_r, digits_ok_nxt;
  logic [SAMPLE_W-1:0] parsed_value_r, parsed_value_nxt;
  logic                is_eol;
  logic                is_digit;

  assign is_eol   = (rx_byte == CHAR_CR);
  assign is_digit = (rx_byte inside {[CHAR_ZERO:CHAR_NINE]});

  // verdict on the line collected so far
  assign status.eol   = byte_en && is_eol;
  assign status.ok    = (line_length_r == LEN_W'(LINE_LEN)) && first_is_r_r && digits_ok_r &&
                        (parsed_value_r != '0) && (parsed_value_r < upper_limit);
  assign status.value = parsed_value_r;

  // line state update
  always_comb begin
    line_length_nxt  = line_length_r;
    first_is_r_nxt   = first_is_r_r;
    digits_ok_nxt    = digits_ok_r;
    parsed_value_nxt = parsed_value_r;
    if (byte_en) begin
      if (is_eol) begin
        line_length_nxt  = '0;
        first_is_r_nxt   = 1'b0;
        digits_ok_nxt    = 1'b1;
        parsed_value_nxt = '0;
      end else if (line_length_r < LEN_W'(LINE_CAPACITY)) begin
        if (line_length_r == '0) begin
          first_is_r_nxt = (rx_byte == CHAR_LEAD);
        end else if (line_length_r < LEN_W'(LINE_LEN)) begin
          if (is_digit) begin
            parsed_value_nxt = parsed_value_r * SAMPLE_W'(10) +
                               SAMPLE_W'(rx_byte - CHAR_ZERO);
          end else begin
            digits_ok_nxt = 1'b0;
          end
        end
        line_length_nxt = line_length_r + LEN_W'(1);
      end else begin
        line_length_nxt = LEN_W'(LINE_CAPACITY + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r  <= '0;
      first_is_r_r   <= 1'b0;
      digits_ok_r    <= 1'b1;
      parsed_value_r <= '0;
    end else begin
      line_length_r  <= line_length_nxt;
      first_is_r_r   <= first_is_r_nxt;
      digits_ok_r    <= digits_ok_nxt;
      parsed_value_r <= parsed_value_nxt;
    end
  end

endmodule

### sv/rlpa_cell.sv
// rlpa_cell: one history cell; holds a sample and takes its neighbor's
// sample on a shift. Depends on rlpa_pkg.
module rlpa_cell
  import rlpa_pkg::*;
(
  input  logic                clk,
  input  logic                shift_en,
  input  logic [SAMPLE_W-1:0] data_i,
  output logic [SAMPLE_W-1:0] data_o
);

  logic [SAMPLE_W-1:0] sample_r;

  // sample moves one cell down the chain
  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= data_i;
    end
  end

  assign data_o = sample_r;

endmodule

### sv/rlpa_history.sv
// rlpa_history: skip counter, chain of history cells, fill count and running
// sum. Depends on rlpa_pkg and rlpa_cell.
module rlpa_history
  import rlpa_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int SUM_W         = SAMPLE_W + $clog2(HISTORY_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  line_status_t      line_i,
  input  logic              skip_load,
  input  logic [SKIP_W-1:0] skip_value,
  output hist_flags_t       flags,
  output logic [SUM_W-1:0]  sum_nxt
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  logic [SAMPLE_W-1:0] tap [HISTORY_DEPTH];
  logic [SKIP_W-1:0]   skips_left_r, skips_left_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [SUM_W-1:0]    sum_r;
  logic                accept_line;
  logic                push;
  logic                is_full;

  assign accept_line = line_i.eol && line_i.ok;
  assign push        = accept_line && (skips_left_r == '0);
  assign is_full     = (fill_r == FILL_W'(HISTORY_DEPTH));

  // chain of cells, newest sample enters at the head, oldest sits at the tail
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      rlpa_cell u_cell (
        .clk      (clk),
        .shift_en (push),
        .data_i   (line_i.value),
        .data_o   (tap[i])
      );
    end else begin : g_body
      rlpa_cell u_cell (
        .clk      (clk),
        .shift_en (push),
        .data_i   (tap[i-1]),
        .data_o   (tap[i])
      );
    end
  end

  // skip counter, reloaded by a register write
  always_comb begin
    skips_left_nxt = skips_left_r;
    if (skip_load) begin
      skips_left_nxt = skip_value;
    end else if (accept_line && (skips_left_r != '0)) begin
      skips_left_nxt = skips_left_r - SKIP_W'(1);
    end
  end

  // fill count and running sum; a full chain drops its tail from the sum
  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (push) begin
      if (is_full) begin
        sum_nxt = sum_r + SUM_W'(line_i.value) - SUM_W'(tap[HISTORY_DEPTH-1]);
      end else begin
        sum_nxt  = sum_r + SUM_W'(line_i.value);
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  assign flags.stored = push;
  assign flags.full   = (fill_nxt == FILL_W'(HISTORY_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skips_left_r <= SKIP_COUNT_RESET;
      fill_r       <= '0;
      sum_r        <= '0;
    end else begin
      skips_left_r <= skips_left_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

  // a full history stays full
  assert property (@(posedge clk) disable iff (!rst_n)
    is_full |=> is_full)
    else $error("history lost its full state");

  // an accepted line counts down the skips instead of storing
  assert property (@(posedge clk) disable iff (!rst_n)
    accept_line && (skips_left_r != '0) && !skip_load
      |=> skips_left_r == $past(skips_left_r) - SKIP_W'(1))
    else $error("skip counter did not count down");

endmodule

### sv/range_line_parser_averager_top.sv
// range_line_parser_averager_top: parses range sensor lines and averages the
// most recent readings. Depends on rlpa_pkg, rlpa_line_parser, rlpa_history.
//
// One received byte is taken every clock cycle while in_ready is high. A carriage
// return yields one result transaction: the line verdict, the cell-chain shift
// and the running sum settle on the edge that takes it, the flags and sum go to
// the pending result stage, and the average (sum times a fixed reciprocal, one
// multiplier) is registered in the output register when that stage moves on.
// Other bytes yield no result. A held-back result stalls input only once both
// the result register and the stage before it are occupied.
module range_line_parser_averager_top
  import rlpa_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_line_stored,
  output logic                  out_history_full,
  output logic [SAMPLE_W-1:0]   out_average_distance,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W   = SAMPLE_W + $clog2(HISTORY_DEPTH);
  localparam int SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  line_status_t        status;
  hist_flags_t         flags;
  logic [SUM_W-1:0]    sum_nxt;
  logic                in_fire;
  logic                skip_load;
  logic [SAMPLE_W-1:0] upper_limit_r;
  logic                p_valid_r;
  hist_flags_t         p_flags_r;
  logic [SUM_W-1:0]    p_sum_r;
  logic                p_move;
  logic [PROD_W-1:0]   prod;
  logic                out_valid_r;
  logic                out_line_stored_r;
  logic                out_history_full_r;
  logic [SAMPLE_W-1:0] out_average_distance_r;

  // handshake
  assign p_move   = p_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p_valid_r || p_move;
  assign in_fire  = in_valid && in_ready;

  // register writes
  always_comb begin
    skip_load = 1'b0;
    case (cfg_index_t'(cfg_index))
      CFG_SKIP_COUNT:  skip_load = cfg_we;
      CFG_UPPER_LIMIT: skip_load = 1'b0;
      default:         skip_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= UPPER_LIMIT_RESET;
    end else if (cfg_we && (cfg_index_t'(cfg_index) == CFG_UPPER_LIMIT)) begin
      upper_limit_r <= cfg_wdata[SAMPLE_W-1:0];
    end
  end

  rlpa_line_parser #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (in_fire),
    .rx_byte     (in_rx_byte),
    .upper_limit (upper_limit_r),
    .status      (status)
  );

  rlpa_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SUM_W         (SUM_W)
  ) u_history (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_i     (status),
    .skip_load  (skip_load),
    .skip_value (cfg_wdata[SKIP_W-1:0]),
    .flags      (flags),
    .sum_nxt    (sum_nxt)
  );

  // pending result stage: flags and sum snapshot at line end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_fire && status.eol) begin
      p_valid_r <= 1'b1;
    end else if (p_move) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && status.eol) begin
      p_flags_r <= flags;
      p_sum_r   <= sum_nxt;
    end
  end

  // divide by depth as multiply by reciprocal and shift
  assign prod = PROD_W'(p_sum_r) * PROD_W'(RECIP);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_line_stored_r      <= p_flags_r.stored;
      out_history_full_r     <= p_flags_r.full;
      out_average_distance_r <= p_flags_r.full ? prod[SHIFT +: SAMPLE_W] : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_line_stored      = out_line_stored_r;
  assign out_history_full     = out_history_full_r;
  assign out_average_distance = out_average_distance_r;

  // every line end taken leaves a pending result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_rx_byte == CHAR_CR) |=> p_valid_r)
    else $error("line end left no pending result");

  // a pending result that cannot move keeps its contents
  assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && !p_move |=> p_valid_r && $stable(p_sum_r) && $stable(p_flags_r))
    else $error("pending result changed while stalled");

  // a moved result shows up at the output with its flags
  assert property (@(posedge clk) disable iff (!rst_n)
    p_move |=> out_valid_r && (out_history_full_r == $past(p_flags_r.full)) &&
               (out_line_stored_r == $past(p_flags_r.stored)))
    else $error("pending result not carried to the output");

endmodule

### tb/range_line_parser_averager_top_test.sv
// range_line_parser_averager_top_test: self-checking testbench for the range line
// parser/averager, with a byte-level predictor and a scoreboard of pending results.
// Depends on rlpa_pkg and range_line_parser_averager_top.
module range_line_parser_averager_top_test
  import rlpa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
  localparam int LINE_CAP     = LINE_CAPACITY_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic                stored;
    logic                full;
    logic [SAMPLE_W-1:0] average;
  } reading_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_line_stored;
  logic                  out_history_full;
  logic [SAMPLE_W-1:0]   out_average_distance;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state: configuration, line parser and sample ring
  logic [SKIP_W-1:0]   skip_setting;
  logic [SAMPLE_W-1:0] limit_setting;
  logic [4:0]          cur_len;
  logic                lead_is_r;
  logic                digits_valid;
  logic [SAMPLE_W-1:0] digit_value;
  logic [SKIP_W-1:0]   skips_remaining;
  logic [SAMPLE_W-1:0] ring_samples [HIST_DEPTH];
  logic [2:0]          ring_fill;
  logic [2:0]          ring_slot;
  logic [16:0]         ring_sum;

  reading_result_t expected_readings [$];
  logic [BYTE_W-1:0] line_bytes [$];
  bit  calm;
  int  err_count;
  int  cycle_count;

  range_line_parser_averager_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_line_stored      (out_line_stored),
    .out_history_full     (out_history_full),
    .out_average_distance (out_average_distance),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // start a fresh line in the predictor
  task clear_line();
    cur_len      = '0;
    lead_is_r    = 1'b0;
    digits_valid = 1'b1;
    digit_value  = '0;
  endtask

  task reset_predictor();
    skip_setting    = SKIP_COUNT_RESET;
    limit_setting   = UPPER_LIMIT_RESET;
    skips_remaining = SKIP_COUNT_RESET;
    clear_line();
    for (int i = 0; i < HIST_DEPTH; i++) ring_samples[i] = '0;
    ring_fill = '0;
    ring_slot = '0;
    ring_sum  = '0;
  endtask

  // predictor: one accepted byte, queue a result on carriage return
  task advance_parser(input logic [BYTE_W-1:0] b);
    reading_result_t res;
    if (b != CHAR_CR) begin
      if (cur_len < LINE_CAP) begin
        if (cur_len == 0) begin
          lead_is_r = (b == CHAR_LEAD);
        end else if (cur_len < LINE_LEN) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            digit_value = digit_value * SAMPLE_W'(10) + SAMPLE_W'(b - CHAR_ZERO);
          end else begin
            digits_valid = 1'b0;
          end
        end
        cur_len = cur_len + 5'd1;
      end else begin
        cur_len = 5'(LINE_CAP + 1);
      end
    end else begin
      res.stored = 1'b0;
      if (cur_len == LINE_LEN && lead_is_r && digits_valid &&
          digit_value > 0 && digit_value < limit_setting) begin
        if (skips_remaining != 0) begin
          skips_remaining = skips_remaining - SKIP_W'(1);
        end else begin
          // full ring: oldest sample leaves the sum
          if (ring_fill >= HIST_DEPTH) begin
            ring_sum = ring_sum - 17'(ring_samples[ring_slot]);
          end else begin
            ring_fill = ring_fill + 3'd1;
          end
          ring_samples[ring_slot] = digit_value;
          ring_sum  = ring_sum + 17'(digit_value);
          ring_slot = (ring_slot == 3'(HIST_DEPTH - 1)) ? '0 : ring_slot + 3'd1;
          res.stored = 1'b1;
        end
      end
      clear_line();
      res.full    = (ring_fill >= HIST_DEPTH);
      res.average = res.full ? SAMPLE_W'(ring_sum / HIST_DEPTH) : '0;
      expected_readings.push_back(res);
    end
  endtask

  // send one byte transaction, after a random idle gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    advance_parser(b);
  endtask

  task automatic send_line_bytes();
    for (int i = 0; i < line_bytes.size(); i++) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CHAR_CR);
  endtask

  // block idle: nothing pending and the pipeline flushed
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drive one register write, enable left high for the caller
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_SKIP_COUNT) begin
      skip_setting    = val[SKIP_W-1:0];
      skips_remaining = val[SKIP_W-1:0];
    end else begin
      limit_setting = val;
    end
  endtask

  // upper data bits of the skip write are junk that must be ignored
  task automatic configure(input logic [SKIP_W-1:0] skip, input logic [SAMPLE_W-1:0] limit);
    wait_idle();
    write_reg(CFG_SKIP_COUNT, {6'($urandom), skip});
    write_reg(CFG_UPPER_LIMIT, limit);
    cfg_we <= 1'b0;
  endtask

  // reading value biased toward the limit edges
  function automatic int pick_reading();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 14) return (limit_setting > 1) ? limit_setting - 1 : 1;
    if (r < 22) return (limit_setting <= 9999) ? limit_setting : 9999;
    if (r < 26) return 9999;
    if (r < 80 && limit_setting > 1) return $urandom_range(1, limit_setting - 1);
    return $urandom_range(0, 9999);
  endfunction

  // one random line: mostly well formed, the rest broken or noise
  task automatic build_random_line();
    int kind;
    int v;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      v = pick_reading();
      line_bytes.push_back((kind >= 76) ? 8'($urandom) : CHAR_LEAD);
      for (int d = 1000; d > 0; d /= 10) line_bytes.push_back(8'(CHAR_ZERO + (v / d) % 10));
      if (kind >= 70 && kind < 76) line_bytes[$urandom_range(1, 4)] = 8'($urandom);
      line_bytes.push_back(CHAR_CR);
    end else if (kind < 86) begin
      n = $urandom_range(0, LINE_CAP + 6);
      line_bytes.push_back(CHAR_LEAD);
      repeat (n) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      line_bytes.push_back(CHAR_CR);
    end else if (kind < 93) begin
      n = $urandom_range(1, 12);
      repeat (n) line_bytes.push_back(8'($urandom));
      line_bytes.push_back(CHAR_CR);
    end else if (kind < 96) begin
      line_bytes.push_back(CHAR_CR);
    end else begin
      // unterminated fragment, runs into the next line
      n = $urandom_range(1, 3);
      line_bytes.push_back(CHAR_LEAD);
      repeat (n) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic run_random_phase(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_line();
      sent += line_bytes.size();
      send_line_bytes();
    end
  endtask

  // reset values: five readings skipped, limit 5000 exclusive
  task automatic test_reset_defaults();
    send_text("R0001");
    send_text("R4999");
    send_text("R5000");
    send_text("R2500");
    send_text("R1234");
    send_text("R0777");
    send_text("R0100");
  endtask

  // line format rules, ring fill and wrap
  task automatic test_line_format();
    configure(8'd0, 14'd9999);
    send_text("R9998");
    send_text("R0000");
    send_text("R9999");
    line_bytes = {CHAR_LEAD, 8'h31, 8'hFF, 8'h33, 8'h34, CHAR_CR};
    send_line_bytes();
    line_bytes = {CHAR_LEAD, 8'h2F, 8'h00, 8'h33, 8'h34, CHAR_CR};
    send_line_bytes();
    line_bytes = {CHAR_LEAD, 8'h31, 8'h32, 8'h33, 8'h3A, CHAR_CR};
    send_line_bytes();
    send_text("X1234");
    send_text("r1234");
    send_text("R123");
    send_text("R12345");
    send_text("");
    send_text("R000000000000001");
    send_text("R0000000000000000001");
    send_text("R0001");
    send_text("R5555");
    send_text("R4321");
    send_text("R2222");
    send_text("R9000");
    send_text("R0042");
  endtask

  // skip count write reloads the skip counter at once
  task automatic test_skip_reload();
    configure(8'd2, 14'd1000);
    send_text("R0500");
    send_text("R0999");
    send_text("R1000");
    send_text("R0998");
  endtask

  // random traffic over several register settings
  task automatic test_random_traffic();
    configure(8'd0, 14'd9999);
    run_random_phase(250);
    configure(8'd3, 14'd1);
    run_random_phase(100);
    configure(8'd255, 14'd9999);
    run_random_phase(120);
    calm = 1'b1;
    configure(8'($urandom_range(0, 10)), 14'($urandom_range(1, 9999)));
    run_random_phase(250);
    calm = 1'b0;
    configure(8'd0, 14'($urandom_range(1, 9999)));
    run_random_phase(250);
    configure(8'($urandom_range(0, 4)), UPPER_LIMIT_RESET);
    run_random_phase(230);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  // result side back-pressure
  initial begin : ready_gen
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest pending reading
  always @(posedge clk) begin : check_results
    reading_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result, average", out_average_distance, 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_line_stored !== want.stored)
          report_mismatch("line_stored", out_line_stored, want.stored);
        if (out_history_full !== want.full)
          report_mismatch("history_full", out_history_full, want.full);
        if (out_average_distance !== want.average)
          report_mismatch("average_distance", out_average_distance, want.average);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL range_line_parser_averager_top");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SKIP_COUNT;
    cfg_wdata  <= '0;
    calm      = 1'b0;
    err_count = 0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_line_format();
    test_skip_reload();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("PASS range_line_parser_averager_top");
    end else begin
      $display("FAIL range_line_parser_averager_top");
    end
    $finish;
  end

endmodule

### sim.f
sv/rlpa_pkg.sv
sv/rlpa_line_parser.sv
sv/rlpa_cell.sv
sv/rlpa_history.sv
sv/range_line_parser_averager_top.sv
tb/range_line_parser_averager_top_test.sv
